// ===== hw/rtl/h264_luma_qpel_interpolator_unit_assert.svh =====
// Assertion macros used by the line buffer of the luma quarter-sample interpolator RTL.
// The including module must provide clk and rst_n.
`ifndef H264_LUMA_QPEL_INTERPOLATOR_UNIT_ASSERT_SVH
`define H264_LUMA_QPEL_INTERPOLATOR_UNIT_ASSERT_SVH

// Checks that the condition holds in the same cycle.
`define HLQI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the condition holds in the next cycle.
`define HLQI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hlqi_pkg.sv =====
// Types, constants and arithmetic helpers of the luma quarter-sample interpolator.
// Used by every RTL module of the block except the RAM; depends on nothing.
`timescale 1ns / 1ps

package hlqi_pkg;

    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int VSUM_W      = 15;
    localparam int NUM_TAPS    = 6;
    localparam int LINE_ROWS   = 5;
    localparam int RS_W        = 3;
    localparam int WIN_EXTRA   = 5;
    localparam int MIN_SIZE    = 4;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 2;
    localparam int SIZE_RESET  = 16;
    localparam int TAP_OUTER   = 5;
    localparam int TAP_INNER   = 20;
    localparam int HALF_ROUND  = 16;
    localparam int HALF_SHIFT  = 5;
    localparam int CTR_ROUND   = 512;
    localparam int CTR_SHIFT   = 10;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic signed [VSUM_W-1:0] vsum_t;
    typedef pixel_t [LINE_ROWS-1:0] line_word_t;
    typedef pixel_t [NUM_TAPS-1:0] column_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAC_X       = 2'd0,
        REG_FRAC_Y       = 2'd1,
        REG_BLOCK_WIDTH  = 2'd2,
        REG_BLOCK_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        POS_FULL = 4'd0,
        POS_A    = 4'd1,
        POS_B    = 4'd2,
        POS_C    = 4'd3,
        POS_D    = 4'd4,
        POS_E    = 4'd5,
        POS_F    = 4'd6,
        POS_G    = 4'd7,
        POS_H    = 4'd8,
        POS_I    = 4'd9,
        POS_J    = 4'd10,
        POS_K    = 4'd11,
        POS_N    = 4'd12,
        POS_P    = 4'd13,
        POS_Q    = 4'd14,
        POS_R    = 4'd15
    } qpel_pos_t;

    typedef struct packed {
        logic has_result;
        logic last;
    } item_tag_t;

    typedef struct packed {
        pixel_t pix_g;
        pixel_t pix_h;
        pixel_t pix_m;
        pixel_t half_b;
        pixel_t half_s;
        pixel_t half_h;
        pixel_t half_m;
        pixel_t half_j;
    } interp_t;

    function automatic vsum_t taps_pix(input pixel_t p0, input pixel_t p1, input pixel_t p2,
                                       input pixel_t p3, input pixel_t p4, input pixel_t p5);
        int acc;
        acc = int'(p0) - TAP_OUTER * int'(p1) + TAP_INNER * int'(p2)
            + TAP_INNER * int'(p3) - TAP_OUTER * int'(p4) + int'(p5);
        return vsum_t'(acc);
    endfunction

    function automatic int taps_sum(input vsum_t v0, input vsum_t v1, input vsum_t v2,
                                    input vsum_t v3, input vsum_t v4, input vsum_t v5);
        return int'(v0) - TAP_OUTER * int'(v1) + TAP_INNER * int'(v2)
            + TAP_INNER * int'(v3) - TAP_OUTER * int'(v4) + int'(v5);
    endfunction

    function automatic pixel_t round_clip(input int v, input int add, input int sh);
        int t;
        t = v + add;
        if (t < 0)
        begin
            return '0;
        end
        t = t >>> sh;
        if (t > PIX_MAX)
        begin
            return pixel_t'(PIX_MAX);
        end
        return pixel_t'(t);
    endfunction

    function automatic pixel_t avg2(input pixel_t a, input pixel_t b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
        return s[PIX_W:1];
    endfunction

endpackage

// ===== hw/rtl/hlqi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Uses no package; instantiated by the line buffer.
`timescale 1ns / 1ps

module hlqi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/hlqi_line_buf.sv =====
// Window position counters, five-row line memory and the column register stage.
// Depends on hlqi_pkg, hlqi_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "h264_luma_qpel_interpolator_unit_assert.svh"

module hlqi_line_buf #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  hlqi_pkg::pixel_t               ref_pixel,
    input  logic [hlqi_pkg::CFG_W-1:0]     block_width,
    input  logic [hlqi_pkg::CFG_W-1:0]     block_height,
    output logic                           col_valid,
    input  logic                           col_ready,
    output hlqi_pkg::column_t              col_data,
    output hlqi_pkg::item_tag_t            col_tag
);

    localparam int LINE_W = MAX_WIDTH + hlqi_pkg::WIN_EXTRA;
    localparam int COL_W  = $clog2(LINE_W);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + hlqi_pkg::WIN_EXTRA);
    localparam int RS_W   = hlqi_pkg::RS_W;

    logic [COL_W-1:0]        col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]        row_cnt_reg, row_cnt_next;
    logic [RS_W-1:0]         rs_reg, rs_next;
    logic [COL_W-1:0]        w_size, w_last;
    logic [ROW_W-1:0]        h_size, h_last;
    logic                    last_col, last_row, has_result;
    logic                    accept, col_move;

    logic                    s1_valid_reg, s1_valid_next;
    hlqi_pkg::pixel_t        s1_pix_reg;
    logic [COL_W-1:0]        s1_addr_reg;
    logic [RS_W-1:0]         s1_rs_reg;
    hlqi_pkg::item_tag_t     s1_tag_reg;

    hlqi_pkg::line_word_t    rd_word, wr_word;

    always_comb
    begin
        if (int'(block_width) < hlqi_pkg::MIN_SIZE)
        begin
            w_size = COL_W'(hlqi_pkg::MIN_SIZE);
        end
        else if (int'(block_width) > MAX_WIDTH)
        begin
            w_size = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_size = COL_W'(block_width);
        end
        if (int'(block_height) < hlqi_pkg::MIN_SIZE)
        begin
            h_size = ROW_W'(hlqi_pkg::MIN_SIZE);
        end
        else if (int'(block_height) > MAX_HEIGHT)
        begin
            h_size = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_size = ROW_W'(block_height);
        end
        w_last = w_size + COL_W'(hlqi_pkg::WIN_EXTRA - 1);
        h_last = h_size + ROW_W'(hlqi_pkg::WIN_EXTRA - 1);
    end

    assign last_col   = col_cnt_reg >= w_last;
    assign last_row   = row_cnt_reg >= h_last;
    assign has_result = (row_cnt_reg >= ROW_W'(hlqi_pkg::WIN_EXTRA))
                     && (col_cnt_reg >= COL_W'(hlqi_pkg::WIN_EXTRA));

    assign col_move = s1_valid_reg && col_ready;
    assign in_stall = s1_valid_reg && !col_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        rs_next      = rs_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                if (last_row)
                begin
                    row_cnt_next = '0;
                    rs_next      = '0;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                    if (rs_reg == RS_W'(hlqi_pkg::LINE_ROWS - 1))
                    begin
                        rs_next = '0;
                    end
                    else
                    begin
                        rs_next = rs_reg + RS_W'(1);
                    end
                end
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (col_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            rs_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            rs_reg       <= rs_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg            <= ref_pixel;
            s1_addr_reg           <= col_cnt_reg;
            s1_rs_reg             <= rs_reg;
            s1_tag_reg.has_result <= has_result;
            s1_tag_reg.last       <= last_col && last_row;
        end
    end

    // The line memory holds, per column, the five most recent rows in rotating slots.
    always_comb
    begin
        logic [RS_W:0] idx_sum;
        logic [RS_W-1:0] idx;
        for (int i = 0; i < hlqi_pkg::LINE_ROWS; i++)
        begin
            idx_sum = {1'b0, s1_rs_reg} + (RS_W + 1)'(i);
            if (idx_sum >= (RS_W + 1)'(hlqi_pkg::LINE_ROWS))
            begin
                idx = RS_W'(idx_sum - (RS_W + 1)'(hlqi_pkg::LINE_ROWS));
            end
            else
            begin
                idx = idx_sum[RS_W-1:0];
            end
            col_data[i] = rd_word[idx];
        end
        col_data[hlqi_pkg::NUM_TAPS-1] = s1_pix_reg;
        wr_word = rd_word;
        wr_word[s1_rs_reg] = s1_pix_reg;
    end

    hlqi_ram #(
        .WIDTH($bits(hlqi_pkg::line_word_t)),
        .DEPTH(LINE_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (col_move),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (rd_word)
    );

    assign col_valid = s1_valid_reg;
    assign col_tag   = s1_tag_reg;

    `HLQI_ASSERT_NEXT(a_col_wrap, accept && last_col, col_cnt_reg == '0,
        "column counter did not wrap after the last window column")
    `HLQI_ASSERT_NEXT(a_block_wrap, accept && last_col && last_row,
        row_cnt_reg == '0 && rs_reg == '0,
        "row counters did not restart after the last window pixel")
    `HLQI_ASSERT_NEXT(a_row_hold, accept && !last_col,
        $stable(row_cnt_reg) && $stable(rs_reg),
        "row counters moved inside a window row")
    `HLQI_ASSERT_NOW(a_phase_zero, row_cnt_reg == '0, rs_reg == '0,
        "line memory phase is not zero at the first window row")

endmodule

// ===== hw/rtl/hlqi_filter.sv =====
// Six-by-six pixel window, vertical tap sums and the half-sample filter stage.
// Depends on hlqi_pkg.
`timescale 1ns / 1ps

module hlqi_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 col_valid,
    output logic                 col_ready,
    input  hlqi_pkg::column_t    col_data,
    input  hlqi_pkg::item_tag_t  col_tag,
    output logic                 res_valid,
    input  logic                 res_ready,
    output hlqi_pkg::interp_t    res_data,
    output logic                 res_last
);

    localparam int N = hlqi_pkg::NUM_TAPS;

    hlqi_pkg::pixel_t   win_reg [N][N];
    hlqi_pkg::vsum_t    vs_reg [N];
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_last_reg;
    logic               s3_valid_reg, s3_valid_next;
    hlqi_pkg::interp_t  s3_data_reg;
    logic               s3_last_reg;
    hlqi_pkg::interp_t  calc;
    logic               col_move, s2_move, s3_move, s3_free;

    assign s3_move   = s3_valid_reg && res_ready;
    assign s3_free   = !s3_valid_reg || s3_move;
    assign s2_move   = s2_valid_reg && s3_free;
    assign col_ready = !s2_valid_reg || s2_move;
    assign col_move  = col_valid && col_ready;

    always_ff @(posedge clk)
    begin
        if (col_move)
        begin
            for (int i = 0; i < N; i++)
            begin
                for (int j = 0; j < N - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][N-1] <= col_data[i];
            end
            for (int j = 0; j < N - 1; j++)
            begin
                vs_reg[j] <= vs_reg[j+1];
            end
            vs_reg[N-1] <= hlqi_pkg::taps_pix(col_data[0], col_data[1], col_data[2],
                                              col_data[3], col_data[4], col_data[5]);
            s2_last_reg <= col_tag.last;
        end
        if (s2_move)
        begin
            s3_data_reg <= calc;
            s3_last_reg <= s2_last_reg;
        end
    end

    always_comb
    begin
        calc.pix_g  = win_reg[2][2];
        calc.pix_h  = win_reg[2][3];
        calc.pix_m  = win_reg[3][2];
        calc.half_b = hlqi_pkg::round_clip(
            int'(hlqi_pkg::taps_pix(win_reg[2][0], win_reg[2][1], win_reg[2][2],
                                    win_reg[2][3], win_reg[2][4], win_reg[2][5])),
            hlqi_pkg::HALF_ROUND, hlqi_pkg::HALF_SHIFT);
        calc.half_s = hlqi_pkg::round_clip(
            int'(hlqi_pkg::taps_pix(win_reg[3][0], win_reg[3][1], win_reg[3][2],
                                    win_reg[3][3], win_reg[3][4], win_reg[3][5])),
            hlqi_pkg::HALF_ROUND, hlqi_pkg::HALF_SHIFT);
        calc.half_h = hlqi_pkg::round_clip(int'(vs_reg[2]), hlqi_pkg::HALF_ROUND,
                                           hlqi_pkg::HALF_SHIFT);
        calc.half_m = hlqi_pkg::round_clip(int'(vs_reg[3]), hlqi_pkg::HALF_ROUND,
                                           hlqi_pkg::HALF_SHIFT);
        calc.half_j = hlqi_pkg::round_clip(
            hlqi_pkg::taps_sum(vs_reg[0], vs_reg[1], vs_reg[2], vs_reg[3], vs_reg[4],
                               vs_reg[5]),
            hlqi_pkg::CTR_ROUND, hlqi_pkg::CTR_SHIFT);
    end

    always_comb
    begin
        if (col_move)
        begin
            s2_valid_next = col_tag.has_result;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
        if (s2_move)
        begin
            s3_valid_next = 1'b1;
        end
        else if (s3_move)
        begin
            s3_valid_next = 1'b0;
        end
        else
        begin
            s3_valid_next = s3_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res_data  = s3_data_reg;
    assign res_last  = s3_last_reg;

endmodule

// ===== hw/rtl/hlqi_out.sv =====
// Quarter-sample selection and averaging, followed by the output register.
// Depends on hlqi_pkg.
`timescale 1ns / 1ps

module hlqi_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    output logic                           res_ready,
    input  hlqi_pkg::interp_t              res_data,
    input  logic                           res_last,
    input  logic [hlqi_pkg::FRAC_W-1:0]    frac_x,
    input  logic [hlqi_pkg::FRAC_W-1:0]    frac_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output hlqi_pkg::pixel_t               pred_pixel,
    output logic                           block_last
);

    logic                 out_valid_reg, out_valid_next;
    hlqi_pkg::pixel_t     pred_reg, pred_next;
    logic                 last_reg;
    hlqi_pkg::qpel_pos_t  pos;

    assign pos       = hlqi_pkg::qpel_pos_t'({frac_y, frac_x});
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (pos)
            hlqi_pkg::POS_FULL: pred_next = res_data.pix_g;
            hlqi_pkg::POS_A:    pred_next = hlqi_pkg::avg2(res_data.pix_g, res_data.half_b);
            hlqi_pkg::POS_B:    pred_next = res_data.half_b;
            hlqi_pkg::POS_C:    pred_next = hlqi_pkg::avg2(res_data.pix_h, res_data.half_b);
            hlqi_pkg::POS_D:    pred_next = hlqi_pkg::avg2(res_data.pix_g, res_data.half_h);
            hlqi_pkg::POS_E:    pred_next = hlqi_pkg::avg2(res_data.half_b, res_data.half_h);
            hlqi_pkg::POS_F:    pred_next = hlqi_pkg::avg2(res_data.half_b, res_data.half_j);
            hlqi_pkg::POS_G:    pred_next = hlqi_pkg::avg2(res_data.half_b, res_data.half_m);
            hlqi_pkg::POS_H:    pred_next = res_data.half_h;
            hlqi_pkg::POS_I:    pred_next = hlqi_pkg::avg2(res_data.half_h, res_data.half_j);
            hlqi_pkg::POS_J:    pred_next = res_data.half_j;
            hlqi_pkg::POS_K:    pred_next = hlqi_pkg::avg2(res_data.half_j, res_data.half_m);
            hlqi_pkg::POS_N:    pred_next = hlqi_pkg::avg2(res_data.pix_m, res_data.half_h);
            hlqi_pkg::POS_P:    pred_next = hlqi_pkg::avg2(res_data.half_h, res_data.half_s);
            hlqi_pkg::POS_Q:    pred_next = hlqi_pkg::avg2(res_data.half_j, res_data.half_s);
            hlqi_pkg::POS_R:    pred_next = hlqi_pkg::avg2(res_data.half_m, res_data.half_s);
            default:            pred_next = res_data.pix_g;
        endcase
    end

    always_comb
    begin
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            pred_reg <= pred_next;
            last_reg <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pred_pixel = pred_reg;
    assign block_last = last_reg;

endmodule

// ===== hw/rtl/h264_luma_qpel_interpolator_unit.sv =====
// Channel   Handshake            Payload
// cfg       cfg_we               cfg_index, cfg_data
// in        in_valid / in_stall  ref_pixel
// out       out_valid / out_stall pred_pixel, block_last
//
// One reference pixel is taken per clock while in_stall is low; its prediction is valid
// at the output once it has passed the column, window, filter and output registers.
// The rate is set by the line memory, which takes one column read and one write per cycle.
// Reset clears the window counters and pipeline valids and loads the register defaults;
// the line memory and pixel window start undefined and need no clearing pass.
// A stall on the output holds the whole pipeline, which then stalls the input.
// Top level of the luma quarter-sample interpolator; depends on hlqi_pkg,
// hlqi_line_buf, hlqi_filter and hlqi_out.
`timescale 1ns / 1ps

module h264_luma_qpel_interpolator_unit #(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_HEIGHT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hlqi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hlqi_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hlqi_pkg::PIX_W-1:0]        ref_pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hlqi_pkg::PIX_W-1:0]        pred_pixel,
    output logic                              block_last
);

    logic [hlqi_pkg::FRAC_W-1:0]  frac_x_reg, frac_x_next;
    logic [hlqi_pkg::FRAC_W-1:0]  frac_y_reg, frac_y_next;
    logic [hlqi_pkg::CFG_W-1:0]   width_reg, width_next;
    logic [hlqi_pkg::CFG_W-1:0]   height_reg, height_next;

    logic                 col_valid, col_ready;
    hlqi_pkg::column_t    col_data;
    hlqi_pkg::item_tag_t  col_tag;
    logic                 res_valid, res_ready, res_last;
    hlqi_pkg::interp_t    res_data;

    always_comb
    begin
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (hlqi_pkg::cfg_reg_t'(cfg_index))
                hlqi_pkg::REG_FRAC_X:       frac_x_next = cfg_data[hlqi_pkg::FRAC_W-1:0];
                hlqi_pkg::REG_FRAC_Y:       frac_y_next = cfg_data[hlqi_pkg::FRAC_W-1:0];
                hlqi_pkg::REG_BLOCK_WIDTH:  width_next  = cfg_data;
                hlqi_pkg::REG_BLOCK_HEIGHT: height_next = cfg_data;
                default:                    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg <= '0;
            frac_y_reg <= '0;
            width_reg  <= hlqi_pkg::CFG_W'(hlqi_pkg::SIZE_RESET);
            height_reg <= hlqi_pkg::CFG_W'(hlqi_pkg::SIZE_RESET);
        end
        else
        begin
            frac_x_reg <= frac_x_next;
            frac_y_reg <= frac_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    hlqi_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ref_pixel    (ref_pixel),
        .block_width  (width_reg),
        .block_height (height_reg),
        .col_valid    (col_valid),
        .col_ready    (col_ready),
        .col_data     (col_data),
        .col_tag      (col_tag)
    );

    hlqi_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col_data  (col_data),
        .col_tag   (col_tag),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .res_last  (res_last)
    );

    hlqi_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .res_last   (res_last),
        .frac_x     (frac_x_reg),
        .frac_y     (frac_y_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pred_pixel (pred_pixel),
        .block_last (block_last)
    );

endmodule

// ===== tb/tb_h264_luma_qpel_interpolator_unit.sv =====
// Self-checking testbench for the luma quarter-sample interpolator unit.
// It predicts every output pixel from the accepted reference pixels and the register state.
// Depends on hlqi_pkg and h264_luma_qpel_interpolator_unit.
`timescale 1ns / 1ps

module tb_h264_luma_qpel_interpolator_unit;

    localparam int MAX_W    = 16;
    localparam int MAX_H    = 16;
    localparam int LINE_LEN = MAX_W + 5;
    localparam int RAND_ITEMS = 700;

    typedef struct packed {
        bit [7:0] pix;
        bit       last;
    } pred_t;

    typedef enum int {
        FILL_CHECKER,
        FILL_TILES,
        FILL_RAILS,
        FILL_NOISE
    } fill_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] ref_pixel = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] pred_pixel;
    logic       block_last;

    h264_luma_qpel_interpolator_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ref_pixel  (ref_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pred_pixel (pred_pixel),
        .block_last (block_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Register mirror and predictor state.
    bit [1:0] cfg_fx = 2'd0;
    bit [1:0] cfg_fy = 2'd0;
    bit [4:0] cfg_w = 5'd16;
    bit [4:0] cfg_h = 5'd16;
    bit [7:0] line_mem [5][LINE_LEN];
    bit [7:0] win [6][6];
    int       vsum [6];
    int       row_cnt = 0;
    int       col_cnt = 0;
    pred_t    expected_preds [$];

    // Stimulus side.
    bit [7:0] pixel_queue [$];
    bit       req_taken = 1'b0;
    bit       calm = 1'b0;
    int       items_queued = 0;
    int       reqs_taken = 0;
    int       preds_seen = 0;
    int       mismatches = 0;
    int       settings_applied = 0;
    int       gen_row = 0;
    int       gen_col = 0;
    bit [4:0] gen_w = 5'd16;
    bit [4:0] gen_h = 5'd16;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 4)
        begin
            return 4;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int tap_sum6(input int a, input int b, input int c,
                                    input int d, input int e, input int f);
        return a - 5 * b + 20 * c + 20 * d - 5 * e + f;
    endfunction

    function automatic int clip_shift(input int v, input int add, input int sh);
        int t;
        t = v + add;
        if (t < 0)
        begin
            return 0;
        end
        t = t >>> sh;
        return (t > 255) ? 255 : t;
    endfunction

    function automatic int mean_up(input int a, input int b);
        return (a + b + 1) >>> 1;
    endfunction

    task automatic compute_prediction(input bit [7:0] px);
        int    w, h, r, c, cc, rs, i, j, p;
        int    colv [6];
        int    g_full, h_full, m_full, b_half, s_half, h_half, m_half, j_half;
        bit    last_col, last_row;
        pred_t item;
        w = clamp_dim(cfg_w, MAX_W);
        h = clamp_dim(cfg_h, MAX_H);
        r = row_cnt;
        c = col_cnt;
        cc = (c < LINE_LEN) ? c : LINE_LEN - 1;
        rs = r % 5;
        last_col = (c >= w + 4);
        last_row = (r >= h + 4);
        for (i = 0; i < 5; i++)
        begin
            colv[i] = line_mem[(rs + i) % 5][cc];
        end
        colv[5] = px;
        line_mem[rs][cc] = px;
        for (i = 0; i < 6; i++)
        begin
            for (j = 0; j < 5; j++)
            begin
                win[i][j] = win[i][j + 1];
            end
            win[i][5] = 8'(colv[i]);
        end
        for (j = 0; j < 5; j++)
        begin
            vsum[j] = vsum[j + 1];
        end
        vsum[5] = tap_sum6(colv[0], colv[1], colv[2], colv[3], colv[4], colv[5]);

        if (r >= 5 && c >= 5)
        begin
            g_full = win[2][2];
            h_full = win[2][3];
            m_full = win[3][2];
            b_half = clip_shift(tap_sum6(win[2][0], win[2][1], win[2][2],
                                         win[2][3], win[2][4], win[2][5]), 16, 5);
            s_half = clip_shift(tap_sum6(win[3][0], win[3][1], win[3][2],
                                         win[3][3], win[3][4], win[3][5]), 16, 5);
            h_half = clip_shift(vsum[2], 16, 5);
            m_half = clip_shift(vsum[3], 16, 5);
            j_half = clip_shift(tap_sum6(vsum[0], vsum[1], vsum[2],
                                         vsum[3], vsum[4], vsum[5]), 512, 10);
            case (hlqi_pkg::qpel_pos_t'({cfg_fy, cfg_fx}))
                hlqi_pkg::POS_FULL: p = g_full;
                hlqi_pkg::POS_A:    p = mean_up(g_full, b_half);
                hlqi_pkg::POS_B:    p = b_half;
                hlqi_pkg::POS_C:    p = mean_up(h_full, b_half);
                hlqi_pkg::POS_D:    p = mean_up(g_full, h_half);
                hlqi_pkg::POS_E:    p = mean_up(b_half, h_half);
                hlqi_pkg::POS_F:    p = mean_up(b_half, j_half);
                hlqi_pkg::POS_G:    p = mean_up(b_half, m_half);
                hlqi_pkg::POS_H:    p = h_half;
                hlqi_pkg::POS_I:    p = mean_up(h_half, j_half);
                hlqi_pkg::POS_J:    p = j_half;
                hlqi_pkg::POS_K:    p = mean_up(j_half, m_half);
                hlqi_pkg::POS_N:    p = mean_up(m_full, h_half);
                hlqi_pkg::POS_P:    p = mean_up(h_half, s_half);
                hlqi_pkg::POS_Q:    p = mean_up(j_half, s_half);
                default:            p = mean_up(m_half, s_half);
            endcase
            item.pix = 8'(p);
            item.last = last_col && last_row;
            expected_preds.push_back(item);
        end

        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    // Request acceptance, prediction and register mirror.
    always @(posedge clk)
    begin
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            compute_prediction(ref_pixel);
            reqs_taken++;
        end
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                hlqi_pkg::REG_FRAC_X:      cfg_fx = cfg_data[1:0];
                hlqi_pkg::REG_FRAC_Y:      cfg_fy = cfg_data[1:0];
                hlqi_pkg::REG_BLOCK_WIDTH: cfg_w = cfg_data;
                default:                   cfg_h = cfg_data;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (!(in_valid && !req_taken))
        begin
            if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 28))
            begin
                in_valid <= 1'b1;
                ref_pixel <= pixel_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 28);
    end

    always @(posedge clk)
    begin
        pred_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            preds_seen++;
            if (expected_preds.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected prediction: pixel %0d last %0b", pred_pixel, block_last);
                end
                mismatches++;
            end
            else
            begin
                want = expected_preds.pop_front();
                if (pred_pixel !== want.pix || block_last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("prediction %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                                 preds_seen, want.pix, want.last, pred_pixel, block_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    function automatic bit [7:0] pick_pixel(input fill_t fill, input int r, input int c);
        case (fill)
            FILL_CHECKER: return ((r + c) & 1) ? 8'd255 : 8'd0;
            FILL_TILES:   return (((r >> 1) + (c >> 1)) & 1) ? 8'd255 : 8'd0;
            FILL_RAILS:   return $urandom_range(1) ? 8'd255 : 8'd0;
            default:      return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic bit [4:0] pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            return 5'd4;
        end
        if (roll < 82)
        begin
            return 5'd8;
        end
        if (roll < 90)
        begin
            return 5'd16;
        end
        return 5'($urandom_range(31));
    endfunction

    // Queues one pixel and tracks the window position it lands on.
    task automatic queue_pixel(input bit [7:0] px, output bit gives_pred);
        int w, h;
        w = clamp_dim(gen_w, MAX_W);
        h = clamp_dim(gen_h, MAX_H);
        gives_pred = (gen_row >= 5 && gen_col >= 5);
        if (gen_col >= w + 4)
        begin
            gen_col = 0;
            gen_row = (gen_row >= h + 4) ? 0 : gen_row + 1;
        end
        else
        begin
            gen_col++;
        end
        pixel_queue.push_back(px);
        items_queued++;
    endtask

    task automatic wait_drain();
        while (reqs_taken != items_queued || expected_preds.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
    endtask

    task automatic apply_setting(input int fx, input int fy, input int bw, input int bh);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= hlqi_pkg::REG_FRAC_X;
        cfg_data <= 5'(fx);
        @(negedge clk);
        cfg_index <= hlqi_pkg::REG_FRAC_Y;
        cfg_data <= 5'(fy);
        @(negedge clk);
        cfg_index <= hlqi_pkg::REG_BLOCK_WIDTH;
        cfg_data <= 5'(bw);
        @(negedge clk);
        cfg_index <= hlqi_pkg::REG_BLOCK_HEIGHT;
        cfg_data <= 5'(bh);
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_w = 5'(bw);
        gen_h = 5'(bh);
        settings_applied++;
    endtask

    initial
    begin
        int       k, phase, rand_items, start;
        bit       got;
        bit [4:0] bw, bh;
        fill_t    fill;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Each of the sixteen positions gets one result from full-swing patterns.
        for (k = 0; k < 16; k++)
        begin
            wait_drain();
            apply_setting(k & 3, k >> 2, 4, 4);
            do
            begin
                queue_pixel(pick_pixel(FILL_CHECKER, gen_row, gen_col), got);
            end
            while (!got);
        end
        // Sizes below the minimum clamp to four.
        for (k = 15; k >= 0; k--)
        begin
            wait_drain();
            apply_setting(k & 3, k >> 2, 0, 2);
            do
            begin
                queue_pixel(pick_pixel(FILL_TILES, gen_row, gen_col), got);
            end
            while (!got);
        end
        // The largest register value clamps to the maximum width.
        wait_drain();
        apply_setting(3, 3, 31, 0);
        do
        begin
            queue_pixel(pick_pixel(FILL_RAILS, gen_row, gen_col), got);
        end
        while (gen_row != 0 || gen_col != 0);

        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS)
        begin
            wait_drain();
            calm = (phase >= 3 && phase <= 5);
            if (gen_row == 0 && gen_col == 0)
            begin
                bw = pick_dim();
                bh = pick_dim();
            end
            else if ($urandom_range(3) == 0)
            begin
                // Shrinking mid-block only revisits columns and rows already written.
                bw = 5'($urandom_range(clamp_dim(gen_w, MAX_W)));
                bh = 5'($urandom_range(clamp_dim(gen_h, MAX_H)));
            end
            else
            begin
                bw = gen_w;
                bh = gen_h;
            end
            apply_setting($urandom_range(3), $urandom_range(3), bw, bh);
            k = $urandom_range(99);
            fill = (k < 80) ? FILL_NOISE : (k < 90) ? FILL_RAILS : FILL_TILES;
            start = items_queued;
            if ($urandom_range(3) != 0)
            begin
                do
                begin
                    queue_pixel(pick_pixel(fill, gen_row, gen_col), got);
                end
                while (gen_row != 0 || gen_col != 0);
            end
            else
            begin
                repeat ($urandom_range(150, 1))
                begin
                    queue_pixel(pick_pixel(fill, gen_row, gen_col), got);
                end
            end
            rand_items += items_queued - start;
            phase++;
        end

        calm = 1'b0;
        wait_drain();
        $display("Run covered %0d requests under %0d register settings, %0d predictions checked.",
                 reqs_taken, settings_applied, preds_seen);
        if (mismatches == 0 && expected_preds.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
